// File: design/farc_pkg.sv
package farc_pkg;

    // Fixed formats of the block's fields and internal arithmetic.
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int TIME_W   = 31;
    localparam int ANGLE_W  = 14;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int WIDE_W   = 128;
    localparam int DEN_W    = 64;
    localparam int CFG_IDX_W = 2;

    // pi/180 in Q30.
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
    // Seven degrees in radians, Q16.16.
    localparam int BETA_MAX = 8007;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_TIME       = 2'd0,
        REG_VELOCITY_GAIN    = 2'd1,
        REG_ACCEL_GAIN       = 2'd2,
        REG_INTEGRATION_MODE = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic {
        MODE_EULER = 1'b0,
        MODE_BDF2  = 1'b1
    } mode_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_ADVANCE,
        CMD_HOLD,
        CMD_MUL_VEL,
        CMD_MUL_ACC,
        CMD_RATE_SUM,
        CMD_MUL_DEG,
        CMD_RAD,
        CMD_MUL_INC,
        CMD_INC,
        CMD_MUL_HH,
        CMD_MUL_DEN,
        CMD_MUL_A_LO,
        CMD_MUL_A_HI,
        CMD_MUL_T_LO,
        CMD_MUL_T_HI,
        CMD_T_DONE,
        CMD_MUL_B0,
        CMD_MUL_B1,
        CMD_MUL_B2,
        CMD_B_DONE,
        CMD_SIGNS,
        CMD_SUM_N,
        CMD_ABS_N,
        CMD_DIV_START,
        CMD_DELTA,
        CMD_FINISH,
        CMD_OUT_LOAD
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_ACC,
        ST_RATE_SUM,
        ST_MUL_DEG,
        ST_RAD,
        ST_MUL_INC,
        ST_INC,
        ST_MUL_HH,
        ST_MUL_DEN,
        ST_MUL_A_LO,
        ST_MUL_A_HI,
        ST_MUL_T_LO,
        ST_MUL_T_HI,
        ST_T_DONE,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_MUL_B2,
        ST_B_DONE,
        ST_SIGNS,
        ST_SUM_N,
        ST_ABS_N,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DELTA,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic advance;
        logic computed;
        logic after_start;
        logic use_euler;
        logic div_done;
        logic out_free;
    } farc_status_t;

endpackage

// File: design/farc_if.sv
interface farc_item_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [farc_pkg::TIME_W-1:0]         sim_time;
    logic [farc_pkg::TIME_W-1:0]         step_size;
    logic [farc_pkg::TIME_W-1:0]         prev_step_size;
    logic                                first_step;
    logic signed [farc_pkg::DATA_W-1:0]  body_velocity_y;
    logic signed [farc_pkg::DATA_W-1:0]  body_accel_y;

    modport source (
        output valid, operation, sim_time, step_size, prev_step_size, first_step,
               body_velocity_y, body_accel_y,
        input  ready
    );
    modport sink (
        input  valid, operation, sim_time, step_size, prev_step_size, first_step,
               body_velocity_y, body_accel_y,
        output ready
    );
endinterface

interface farc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [farc_pkg::ANGLE_W-1:0] flap_angle;
    logic                                limited;

    modport source (output valid, flap_angle, limited, input ready);
    modport sink (input valid, flap_angle, limited, output ready);
endinterface

// File: design/farc_div.sv
module farc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [farc_pkg::WIDE_W-1:0]   numer,
    input  logic [farc_pkg::DEN_W-1:0]    denom,
    output logic [farc_pkg::DEN_W-1:0]    quot,
    output logic                          done
);

    // Restoring division, two quotient bits per cycle.
    localparam int BITS_PER_CYCLE = 2;
    localparam int CYCLES = farc_pkg::WIDE_W / BITS_PER_CYCLE;
    localparam int CNT_W = $clog2(CYCLES);
    localparam int DW = farc_pkg::DEN_W;

    logic [farc_pkg::WIDE_W-1:0] num_reg, num_next;
    logic [DW-1:0]               rem_reg, rem_next;
    logic [DW-1:0]               quot_reg, quot_next;
    logic [DW-1:0]               den_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    always_comb
    begin
        logic [DW:0] trial;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            trial    = {rem_next, num_next[farc_pkg::WIDE_W-1]};
            num_next = {num_next[farc_pkg::WIDE_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial     = trial - {1'b0, den_reg};
                quot_next = {quot_next[DW-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_next[DW-2:0], 1'b0};
            end
            rem_next = trial[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= numer;
            den_reg  <= denom;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// File: design/farc_datapath.sv
module farc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [farc_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [farc_pkg::DATA_W-1:0]           wr_data,
    input  farc_pkg::cmd_t                        cmd,
    output farc_pkg::farc_status_t                status,
    input  logic                                  operation,
    input  logic [farc_pkg::TIME_W-1:0]           sim_time,
    input  logic [farc_pkg::TIME_W-1:0]           step_size,
    input  logic [farc_pkg::TIME_W-1:0]           prev_step_size,
    input  logic                                  first_step,
    input  logic signed [farc_pkg::DATA_W-1:0]    body_velocity_y,
    input  logic signed [farc_pkg::DATA_W-1:0]    body_accel_y,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic signed [farc_pkg::ANGLE_W-1:0]   res_angle,
    output logic                                  res_limited
);

    localparam int AW = farc_pkg::ANGLE_W;
    localparam int TW = farc_pkg::TIME_W;
    localparam int PW = farc_pkg::PROD_W;
    localparam int WW = farc_pkg::WIDE_W;
    localparam logic signed [52:0] RATE_HI = 53'sd2147483647;
    localparam logic signed [52:0] RATE_LO = -53'sd2147483648;
    localparam logic signed [47:0] ANG_HI = 48'(farc_pkg::BETA_MAX);
    localparam logic signed [47:0] ANG_LO = -48'(farc_pkg::BETA_MAX);

    // Configuration registers.
    logic [TW-1:0]                       start_reg;
    logic signed [farc_pkg::DATA_W-1:0]  vgain_reg;
    logic signed [farc_pkg::DATA_W-1:0]  again_reg;
    logic                                mode_reg;

    // Angle history and step flag.
    logic signed [AW-1:0] now_reg, prev_reg, prev2_reg;
    logic                 computed_reg;
    logic                 limited_reg;

    // Latched input word.
    logic                               op_reg;
    logic [TW-1:0]                      time_reg, h_reg, h0_reg;
    logic                               first_reg;
    logic signed [farc_pkg::DATA_W-1:0] vel_reg, accel_reg;

    // Working registers.
    logic signed [PW-1:0] prod_reg;
    logic signed [51:0]   p1_reg;
    logic signed [31:0]   rate_reg;
    logic signed [33:0]   rr_reg;
    logic signed [63:0]   inc_reg;
    logic [63:0]          inc_mag_reg;
    logic [TW+1:0]        tw_reg;
    logic [TW:0]          hph_reg;
    logic [AW:0]          dmag_reg;
    logic                 dneg_reg;
    logic [61:0]          hh_reg;
    logic [63:0]          den_reg;
    logic [WW-1:0]        wacc_reg;
    logic [WW-1:0]        a_reg;
    logic [95:0]          t_reg;
    logic                 nneg_reg;

    // Result register.
    logic                 res_valid_reg;
    logic signed [AW-1:0] res_angle_reg;
    logic                 res_limited_reg;

    logic signed [farc_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [PW-1:0]              prod_next;
    logic signed [52:0]                rate_sum;
    logic signed [31:0]                rate_sat;
    logic [63:0]                       inc_abs;
    logic signed [AW:0]                diff;
    logic [WW-1:0]                     prod_wide;
    logic signed [63:0]                cand;
    logic signed [63:0]                rounded;
    logic signed [47:0]                ang_val;
    logic signed [AW-1:0]              ang_clamped;
    logic                              ang_limited;
    logic [63:0]                       quot;
    logic                              div_done;

    farc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd == farc_pkg::CMD_DIV_START),
        .numer (wacc_reg),
        .denom (den_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // Operand selection for the shared signed multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            farc_pkg::CMD_MUL_VEL:
            begin
                mul_a = 34'(vgain_reg);
                mul_b = 34'(vel_reg);
            end
            farc_pkg::CMD_MUL_ACC:
            begin
                mul_a = 34'(again_reg);
                mul_b = 34'(accel_reg);
            end
            farc_pkg::CMD_MUL_DEG:
            begin
                mul_a = 34'(rate_reg);
                mul_b = $signed({9'b0, farc_pkg::DEG_TO_RAD_Q30});
            end
            farc_pkg::CMD_MUL_INC:
            begin
                mul_a = rr_reg;
                mul_b = $signed({3'b0, h_reg});
            end
            farc_pkg::CMD_MUL_HH:
            begin
                mul_a = $signed({3'b0, h_reg});
                mul_b = $signed({3'b0, h_reg});
            end
            farc_pkg::CMD_MUL_DEN:
            begin
                mul_a = $signed({3'b0, h0_reg});
                mul_b = $signed({1'b0, tw_reg});
            end
            farc_pkg::CMD_MUL_A_LO:
            begin
                mul_a = $signed({19'b0, dmag_reg});
                mul_b = $signed({2'b0, hh_reg[31:0]});
            end
            farc_pkg::CMD_MUL_A_HI:
            begin
                mul_a = $signed({19'b0, dmag_reg});
                mul_b = $signed({4'b0, hh_reg[61:32]});
            end
            farc_pkg::CMD_MUL_T_LO:
            begin
                mul_a = $signed({2'b0, inc_mag_reg[31:0]});
                mul_b = $signed({2'b0, hph_reg});
            end
            farc_pkg::CMD_MUL_T_HI:
            begin
                mul_a = $signed({2'b0, inc_mag_reg[63:32]});
                mul_b = $signed({2'b0, hph_reg});
            end
            farc_pkg::CMD_MUL_B0:
            begin
                mul_a = $signed({2'b0, wacc_reg[31:0]});
                mul_b = $signed({3'b0, h0_reg});
            end
            farc_pkg::CMD_MUL_B1:
            begin
                mul_a = $signed({2'b0, t_reg[63:32]});
                mul_b = $signed({3'b0, h0_reg});
            end
            farc_pkg::CMD_MUL_B2:
            begin
                mul_a = $signed({2'b0, t_reg[95:64]});
                mul_b = $signed({3'b0, h0_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Rate sum with saturation to 32 signed bits.
    assign rate_sum = {p1_reg[51], p1_reg} + {prod_reg[PW-1], prod_reg[PW-1:16]};
    assign rate_sat = (rate_sum > RATE_HI) ? 32'sh7FFF_FFFF :
                      (rate_sum < RATE_LO) ? $signed(32'h8000_0000) : rate_sum[31:0];

    assign inc_abs   = prod_reg[63] ? (64'd0 - prod_reg[63:0]) : prod_reg[63:0];
    assign diff      = {prev_reg[AW-1], prev_reg} - {prev2_reg[AW-1], prev2_reg};
    assign prod_wide = {64'd0, prod_reg[63:0]};

    // New angle: round to Q16.16 and clamp to the travel limit.
    assign cand    = $signed({{(64 - AW - farc_pkg::FRAC_W){prev_reg[AW-1]}}, prev_reg,
                              {farc_pkg::FRAC_W{1'b0}}}) + inc_reg;
    assign rounded = cand + 64'sd32768;
    assign ang_val = rounded[63:16];

    always_comb
    begin
        ang_limited = 1'b0;
        ang_clamped = ang_val[AW-1:0];
        if (ang_val > ANG_HI)
        begin
            ang_clamped = ANG_HI[AW-1:0];
            ang_limited = 1'b1;
        end
        else if (ang_val < ANG_LO)
        begin
            ang_clamped = ANG_LO[AW-1:0];
            ang_limited = 1'b1;
        end
    end

    // Configuration, history, flags and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg       <= '0;
            vgain_reg       <= '0;
            again_reg       <= '0;
            mode_reg        <= farc_pkg::MODE_BDF2;
            now_reg         <= '0;
            prev_reg        <= '0;
            prev2_reg       <= '0;
            computed_reg    <= 1'b0;
            limited_reg     <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    farc_pkg::REG_START_TIME:       start_reg <= wr_data[TW-1:0];
                    farc_pkg::REG_VELOCITY_GAIN:    vgain_reg <= wr_data;
                    farc_pkg::REG_ACCEL_GAIN:       again_reg <= wr_data;
                    farc_pkg::REG_INTEGRATION_MODE: mode_reg  <= wr_data[0];
                    default:                        start_reg <= start_reg;
                endcase
            end

            case (cmd)
                farc_pkg::CMD_LATCH:
                begin
                    limited_reg <= 1'b0;
                end
                farc_pkg::CMD_ADVANCE:
                begin
                    prev2_reg    <= prev_reg;
                    prev_reg     <= now_reg;
                    computed_reg <= 1'b0;
                end
                farc_pkg::CMD_HOLD:
                begin
                    now_reg      <= prev_reg;
                    computed_reg <= 1'b1;
                end
                farc_pkg::CMD_FINISH:
                begin
                    now_reg      <= ang_clamped;
                    limited_reg  <= ang_limited;
                    computed_reg <= 1'b1;
                end
                default:
                begin
                    computed_reg <= computed_reg;
                end
            endcase

            if (cmd == farc_pkg::CMD_OUT_LOAD)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the arithmetic sequence.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (cmd)
            farc_pkg::CMD_LATCH:
            begin
                op_reg    <= operation;
                time_reg  <= sim_time;
                h_reg     <= step_size;
                h0_reg    <= prev_step_size;
                first_reg <= first_step;
                vel_reg   <= body_velocity_y;
                accel_reg <= body_accel_y;
            end
            farc_pkg::CMD_MUL_ACC:
            begin
                p1_reg <= prod_reg[PW-1:16];
            end
            farc_pkg::CMD_RATE_SUM:
            begin
                rate_reg <= rate_sat;
            end
            farc_pkg::CMD_RAD:
            begin
                rr_reg <= prod_reg[63:30];
            end
            farc_pkg::CMD_INC:
            begin
                inc_reg     <= prod_reg[63:0];
                inc_mag_reg <= inc_abs;
            end
            farc_pkg::CMD_MUL_HH:
            begin
                tw_reg   <= {1'b0, h_reg, 1'b0} + {2'b0, h0_reg};
                hph_reg  <= {1'b0, h_reg} + {1'b0, h0_reg};
                dneg_reg <= diff[AW];
                dmag_reg <= diff[AW] ? (AW + 1)'(-diff) : diff;
            end
            farc_pkg::CMD_MUL_DEN:
            begin
                hh_reg <= prod_reg[61:0];
            end
            farc_pkg::CMD_MUL_A_LO:
            begin
                den_reg <= prod_reg[63:0];
            end
            farc_pkg::CMD_MUL_A_HI:
            begin
                wacc_reg <= prod_wide;
            end
            farc_pkg::CMD_MUL_T_LO:
            begin
                wacc_reg <= wacc_reg + (prod_wide << 32);
            end
            farc_pkg::CMD_MUL_T_HI:
            begin
                a_reg    <= wacc_reg;
                wacc_reg <= prod_wide;
            end
            farc_pkg::CMD_T_DONE:
            begin
                wacc_reg <= wacc_reg + (prod_wide << 32);
            end
            farc_pkg::CMD_MUL_B0:
            begin
                t_reg <= wacc_reg[95:0];
            end
            farc_pkg::CMD_MUL_B1:
            begin
                wacc_reg <= prod_wide;
            end
            farc_pkg::CMD_MUL_B2:
            begin
                wacc_reg <= wacc_reg + (prod_wide << 32);
            end
            farc_pkg::CMD_B_DONE:
            begin
                wacc_reg <= wacc_reg + (prod_wide << 64);
            end
            farc_pkg::CMD_SIGNS:
            begin
                wacc_reg <= inc_reg[63] ? (WW'(0) - wacc_reg) : wacc_reg;
                a_reg    <= dneg_reg ? (WW'(0) - (a_reg << 16)) : (a_reg << 16);
            end
            farc_pkg::CMD_SUM_N:
            begin
                wacc_reg <= wacc_reg + a_reg;
            end
            farc_pkg::CMD_ABS_N:
            begin
                nneg_reg <= wacc_reg[WW-1];
                wacc_reg <= wacc_reg[WW-1] ? (WW'(0) - wacc_reg) : wacc_reg;
            end
            farc_pkg::CMD_DELTA:
            begin
                inc_reg <= nneg_reg ? $signed(64'd0 - quot) : $signed(quot);
            end
            farc_pkg::CMD_OUT_LOAD:
            begin
                res_angle_reg   <= now_reg;
                res_limited_reg <= limited_reg;
            end
            default:
            begin
                p1_reg <= p1_reg;
            end
        endcase
    end

    assign status.advance     = (op_reg == farc_pkg::OP_ADVANCE);
    assign status.computed    = computed_reg;
    assign status.after_start = (time_reg > start_reg);
    assign status.use_euler   = (mode_reg == farc_pkg::MODE_EULER) || first_reg ||
                                (h0_reg == '0);
    assign status.div_done    = div_done;
    assign status.out_free    = !res_valid_reg || res_ready;

    assign res_valid   = res_valid_reg;
    assign res_angle   = res_angle_reg;
    assign res_limited = res_limited_reg;

endmodule

// File: design/farc_ctrl.sv
module farc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  farc_pkg::farc_status_t status,
    output farc_pkg::cmd_t         cmd
);

    farc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= farc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            farc_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = farc_pkg::ST_DECIDE;
                end
            end
            farc_pkg::ST_DECIDE:
            begin
                if (status.advance || status.computed || !status.after_start)
                begin
                    state_next = farc_pkg::ST_OUT;
                end
                else
                begin
                    state_next = farc_pkg::ST_MUL_ACC;
                end
            end
            farc_pkg::ST_MUL_ACC:   state_next = farc_pkg::ST_RATE_SUM;
            farc_pkg::ST_RATE_SUM:  state_next = farc_pkg::ST_MUL_DEG;
            farc_pkg::ST_MUL_DEG:   state_next = farc_pkg::ST_RAD;
            farc_pkg::ST_RAD:       state_next = farc_pkg::ST_MUL_INC;
            farc_pkg::ST_MUL_INC:   state_next = farc_pkg::ST_INC;
            farc_pkg::ST_INC:
            begin
                state_next = status.use_euler ? farc_pkg::ST_FINISH : farc_pkg::ST_MUL_HH;
            end
            farc_pkg::ST_MUL_HH:    state_next = farc_pkg::ST_MUL_DEN;
            farc_pkg::ST_MUL_DEN:   state_next = farc_pkg::ST_MUL_A_LO;
            farc_pkg::ST_MUL_A_LO:  state_next = farc_pkg::ST_MUL_A_HI;
            farc_pkg::ST_MUL_A_HI:  state_next = farc_pkg::ST_MUL_T_LO;
            farc_pkg::ST_MUL_T_LO:  state_next = farc_pkg::ST_MUL_T_HI;
            farc_pkg::ST_MUL_T_HI:  state_next = farc_pkg::ST_T_DONE;
            farc_pkg::ST_T_DONE:    state_next = farc_pkg::ST_MUL_B0;
            farc_pkg::ST_MUL_B0:    state_next = farc_pkg::ST_MUL_B1;
            farc_pkg::ST_MUL_B1:    state_next = farc_pkg::ST_MUL_B2;
            farc_pkg::ST_MUL_B2:    state_next = farc_pkg::ST_B_DONE;
            farc_pkg::ST_B_DONE:    state_next = farc_pkg::ST_SIGNS;
            farc_pkg::ST_SIGNS:     state_next = farc_pkg::ST_SUM_N;
            farc_pkg::ST_SUM_N:     state_next = farc_pkg::ST_ABS_N;
            farc_pkg::ST_ABS_N:     state_next = farc_pkg::ST_DIV_START;
            farc_pkg::ST_DIV_START: state_next = farc_pkg::ST_DIV_WAIT;
            farc_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = farc_pkg::ST_DELTA;
                end
            end
            farc_pkg::ST_DELTA:     state_next = farc_pkg::ST_FINISH;
            farc_pkg::ST_FINISH:    state_next = farc_pkg::ST_OUT;
            farc_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = farc_pkg::ST_IDLE;
                end
            end
            default:                state_next = farc_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd = farc_pkg::CMD_NOP;
        case (state_reg)
            farc_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd = farc_pkg::CMD_LATCH;
                end
            end
            farc_pkg::ST_DECIDE:
            begin
                if (status.advance)
                begin
                    cmd = farc_pkg::CMD_ADVANCE;
                end
                else if (status.computed)
                begin
                    cmd = farc_pkg::CMD_NOP;
                end
                else if (!status.after_start)
                begin
                    cmd = farc_pkg::CMD_HOLD;
                end
                else
                begin
                    cmd = farc_pkg::CMD_MUL_VEL;
                end
            end
            farc_pkg::ST_MUL_ACC:   cmd = farc_pkg::CMD_MUL_ACC;
            farc_pkg::ST_RATE_SUM:  cmd = farc_pkg::CMD_RATE_SUM;
            farc_pkg::ST_MUL_DEG:   cmd = farc_pkg::CMD_MUL_DEG;
            farc_pkg::ST_RAD:       cmd = farc_pkg::CMD_RAD;
            farc_pkg::ST_MUL_INC:   cmd = farc_pkg::CMD_MUL_INC;
            farc_pkg::ST_INC:       cmd = farc_pkg::CMD_INC;
            farc_pkg::ST_MUL_HH:    cmd = farc_pkg::CMD_MUL_HH;
            farc_pkg::ST_MUL_DEN:   cmd = farc_pkg::CMD_MUL_DEN;
            farc_pkg::ST_MUL_A_LO:  cmd = farc_pkg::CMD_MUL_A_LO;
            farc_pkg::ST_MUL_A_HI:  cmd = farc_pkg::CMD_MUL_A_HI;
            farc_pkg::ST_MUL_T_LO:  cmd = farc_pkg::CMD_MUL_T_LO;
            farc_pkg::ST_MUL_T_HI:  cmd = farc_pkg::CMD_MUL_T_HI;
            farc_pkg::ST_T_DONE:    cmd = farc_pkg::CMD_T_DONE;
            farc_pkg::ST_MUL_B0:    cmd = farc_pkg::CMD_MUL_B0;
            farc_pkg::ST_MUL_B1:    cmd = farc_pkg::CMD_MUL_B1;
            farc_pkg::ST_MUL_B2:    cmd = farc_pkg::CMD_MUL_B2;
            farc_pkg::ST_B_DONE:    cmd = farc_pkg::CMD_B_DONE;
            farc_pkg::ST_SIGNS:     cmd = farc_pkg::CMD_SIGNS;
            farc_pkg::ST_SUM_N:     cmd = farc_pkg::CMD_SUM_N;
            farc_pkg::ST_ABS_N:     cmd = farc_pkg::CMD_ABS_N;
            farc_pkg::ST_DIV_START: cmd = farc_pkg::CMD_DIV_START;
            farc_pkg::ST_DELTA:     cmd = farc_pkg::CMD_DELTA;
            farc_pkg::ST_FINISH:    cmd = farc_pkg::CMD_FINISH;
            farc_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd = farc_pkg::CMD_OUT_LOAD;
                end
            end
            default:                cmd = farc_pkg::CMD_NOP;
        endcase
    end

    assign item_ready = (state_reg == farc_pkg::ST_IDLE);

endmodule

// File: design/flap_angle_rate_controller_unit.sv
// Flap angle rate controller. Each input word is either a compute request or
// a step advance, and each produces exactly one result word carrying the flap
// angle (Q16.16 radians, clamped to plus or minus seven degrees) and a flag
// that tells whether this compute hit the clamp. A compute forms a rate
// command from the body's vertical velocity and acceleration, converts it to
// radians per second and integrates the angle by forward Euler or by
// variable-step BDF2; it acts once per step, before the start time it only
// holds the previous angle, and an advance word commits the step and shifts
// the angle history. Words are processed one at a time: an advance, a repeated
// compute or a compute before the start time goes from the decision straight
// to the output state, an Euler compute runs the rate and increment steps, and
// a BDF2 compute adds the history terms and waits on the 128-by-64-bit
// restoring divider that retires two quotient bits per cycle; a new word is
// accepted on the cycle after the result enters the output register, even if
// that result has not yet been taken. All multiplications use one shared
// 34-by-34-bit multiplier whose product is registered before use, and wide
// products are built from 32-bit partial products accumulated in sequence.
// Configuration registers are written through the plain write port
// (start time, velocity gain, acceleration gain, integration mode) and must
// only be written while the block is idle.
module flap_angle_rate_controller_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [farc_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [farc_pkg::DATA_W-1:0]          wr_data,
    farc_item_if.sink                            item,
    farc_result_if.source                        result
);

    farc_pkg::farc_status_t status;
    farc_pkg::cmd_t         cmd;
    logic                   item_ready;

    // The controller sequences the arithmetic; it sees only item valid and status flags.
    farc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds configuration, angle history, working registers,
    // the shared multiplier, the divider and the output register.
    farc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .cmd             (cmd),
        .status          (status),
        .operation       (item.operation),
        .sim_time        (item.sim_time),
        .step_size       (item.step_size),
        .prev_step_size  (item.prev_step_size),
        .first_step      (item.first_step),
        .body_velocity_y (item.body_velocity_y),
        .body_accel_y    (item.body_accel_y),
        .res_valid       (result.valid),
        .res_ready       (result.ready),
        .res_angle       (result.flap_angle),
        .res_limited     (result.limited)
    );

    assign item.ready = item_ready;

endmodule
